[rtl/adfs_pkg.sv]
// adfs_pkg: shared types, character codes and the 10^-k double table
// for the decimal scanner; no dependencies
package adfs_pkg;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  localparam int QUEUE_DEPTH = 4;

  // float32 exponent bias less the double bias and the product alignment
  localparam logic [11:0] EXP_OFFSET = 12'd833;

  typedef enum logic [2:0] {
    MODE_SKIP = 3'b001,
    MODE_INT  = 3'b010,
    MODE_FRAC = 3'b100
  } scan_mode_t;

  typedef struct packed {
    logic [63:0] acc;
    logic        neg;
    logic [4:0]  frac_cnt;
    logic        trunc;
  } job_t;

  // 10^-k as an ieee double bit pattern, k above 17 clamps to 17
  function automatic logic [63:0] pow10_neg(input logic [4:0] k);
    logic [63:0] r;
    case (k)
      5'd0:    r = 64'h3FF0000000000000;
      5'd1:    r = 64'h3FB999999999999A;
      5'd2:    r = 64'h3F847AE147AE147B;
      5'd3:    r = 64'h3F50624DD2F1A9FC;
      5'd4:    r = 64'h3F1A36E2EB1C432D;
      5'd5:    r = 64'h3EE4F8B588E368F1;
      5'd6:    r = 64'h3EB0C6F7A0B5ED8D;
      5'd7:    r = 64'h3E7AD7F29ABCAF48;
      5'd8:    r = 64'h3E45798EE2308C3A;
      5'd9:    r = 64'h3E112E0BE826D695;
      5'd10:   r = 64'h3DDB7CDFD9D7BDBB;
      5'd11:   r = 64'h3DA5FD7FE1796495;
      5'd12:   r = 64'h3D719799812DEA11;
      5'd13:   r = 64'h3D3C25C268497682;
      5'd14:   r = 64'h3D06849B86A12B9B;
      5'd15:   r = 64'h3CD203AF9EE75616;
      5'd16:   r = 64'h3C9CD2B297D889BC;
      default: r = 64'h3C670EF54646D497;
    endcase
    return r;
  endfunction

endpackage

[rtl/adfs_text_if.sv]
// adfs_text_if: request channel carrying one text byte and the flush mark
// no dependencies
interface adfs_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       flush;

  modport source (output valid, char_byte, flush, input ready);
  modport sink (input valid, char_byte, flush, output ready);
endinterface

[rtl/adfs_num_if.sv]
// adfs_num_if: request channel carrying one parsed float32 number
// no dependencies
interface adfs_num_if;
  logic        valid;
  logic        ready;
  logic [31:0] value_bits;
  logic        fraction_truncated;

  modport source (output valid, value_bits, fraction_truncated, input ready);
  modport sink (input valid, value_bits, fraction_truncated, output ready);
endinterface

[rtl/adfs_front.sv]
// adfs_front: byte scanner, gathers digits and hands finished numbers on
// depends on adfs_pkg
module adfs_front import adfs_pkg::*; #(
  parameter int MAX_FRACTION_DIGITS = 17
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  logic [7:0] char_byte,
  input  logic       flush,
  output logic       emit,
  output job_t       job
);

  scan_mode_t  mode, mode_next;
  logic [63:0] acc, acc_next;
  logic        neg, neg_next;
  logic [4:0]  cnt, cnt_next;
  logic        trunc, trunc_next;

  logic        is_digit;
  logic [63:0] digit;
  logic [63:0] mac;
  scan_mode_t  start_mode;
  logic [63:0] start_acc;
  logic        start_neg;
  logic        ends;

  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign digit    = {60'd0, 4'(char_byte - CH_ZERO)};
  assign mac      = (acc << 3) + (acc << 1) + digit;

  always_comb begin
    start_mode = MODE_SKIP;
    start_acc  = '0;
    start_neg  = 1'b0;
    if (is_digit) begin
      start_mode = MODE_INT;
      start_acc  = digit;
    end else if (char_byte == CH_MINUS) begin
      start_mode = MODE_INT;
      start_neg  = 1'b1;
    end else if (char_byte == CH_POINT) begin
      start_mode = MODE_FRAC;
    end
  end

  always_comb begin
    mode_next  = mode;
    acc_next   = acc;
    neg_next   = neg;
    cnt_next   = cnt;
    trunc_next = trunc;
    ends       = 1'b0;
    if (flush) begin
      ends       = (mode != MODE_SKIP);
      mode_next  = MODE_SKIP;
      acc_next   = '0;
      neg_next   = 1'b0;
      cnt_next   = '0;
      trunc_next = 1'b0;
    end else begin
      unique case (mode)
        MODE_INT: begin
          if (is_digit) begin
            acc_next = mac;
          end else if (char_byte == CH_POINT) begin
            mode_next = MODE_FRAC;
          end else begin
            ends = 1'b1;
          end
        end
        MODE_FRAC: begin
          if (is_digit) begin
            if (cnt < 5'(MAX_FRACTION_DIGITS)) begin
              acc_next = mac;
              cnt_next = cnt + 5'd1;
            end else begin
              trunc_next = 1'b1;
            end
          end else begin
            ends = 1'b1;
          end
        end
        default: begin
          ends = 1'b0;
        end
      endcase
      if (mode == MODE_SKIP || ends) begin
        mode_next  = start_mode;
        acc_next   = start_acc;
        neg_next   = start_neg;
        cnt_next   = '0;
        trunc_next = 1'b0;
      end
    end
  end

  assign emit = take && ends;
  assign job  = '{acc: acc, neg: neg, frac_cnt: cnt, trunc: trunc};

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_SKIP;
      acc   <= '0;
      neg   <= 1'b0;
      cnt   <= '0;
      trunc <= 1'b0;
    end else if (take) begin
      mode  <= mode_next;
      acc   <= acc_next;
      neg   <= neg_next;
      cnt   <= cnt_next;
      trunc <= trunc_next;
    end
  end

  a_emit_open : assert property (@(posedge clk) disable iff (rst)
    emit |-> mode != MODE_SKIP)
    else $error("number emitted while skipping");

endmodule

[rtl/adfs_queue.sv]
// adfs_queue: short job queue between the scanner and the converter
// depends on adfs_pkg
module adfs_queue import adfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;
  logic          pop;

  assign full      = (count == (PW+1)'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      if (push && !pop) count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

  a_fill : assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (PW+1)'(1))
    else $error("queue count missed a push");

  a_drain : assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - (PW+1)'(1))
    else $error("queue count missed a pop");

endmodule

[rtl/adfs_back.sv]
// adfs_back: converter pipeline, u64 to double, times 10^-k, to float32
// depends on adfs_pkg and adfs_num_if
module adfs_back import adfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  job_t       in_job,
  adfs_num_if.source number
);

  logic en;
  assign en       = !number.valid || number.ready;
  assign in_ready = en;

  // leading zero count
  logic [5:0] lz_in;
  always_comb begin
    lz_in = '0;
    for (int i = 0; i < 64; i++) begin
      if (in_job.acc[i]) lz_in = 6'(63 - i);
    end
  end

  logic        v2, neg2, tr2, zero2;
  logic [63:0] acc2;
  logic [5:0]  lz2;
  logic [4:0]  k2;

  // normalise and round the integer to 53 bits
  logic [63:0] norm;
  logic        rnd_a;
  logic [53:0] sum_a;
  logic [52:0] m_a;
  logic [63:0] dbits;
  logic [11:0] eb_a;
  always_comb begin
    norm  = acc2 << lz2;
    rnd_a = norm[10] && ((|norm[9:0]) || norm[11]);
    sum_a = {1'b0, norm[63:11]} + 54'(rnd_a);
    m_a   = sum_a[53] ? {1'b1, 52'd0} : sum_a[52:0];
    dbits = pow10_neg(k2);
    eb_a  = 12'(dbits[62:52]) - 12'(lz2) + 12'(sum_a[53]);
  end

  logic        v3, neg3, tr3, zero3;
  logic [52:0] ma3, md3;
  logic [11:0] eb3;

  logic        v4, neg4, tr4, zero4;
  logic [53:0] pp_ll;
  logic [52:0] pp_lh, pp_hl;
  logic [51:0] pp_hh;
  logic [11:0] eb4;

  logic         v5, neg5, tr5, zero5;
  logic [105:0] prod5;
  logic [11:0]  eb5;

  // round the product to a double
  logic        top;
  logic [52:0] keep;
  logic        rnd_p;
  logic [53:0] sum_p;
  logic [52:0] m_p;
  always_comb begin
    top = prod5[105];
    if (top) begin
      keep  = prod5[105:53];
      rnd_p = prod5[52] && ((|prod5[51:0]) || keep[0]);
    end else begin
      keep  = prod5[104:52];
      rnd_p = prod5[51] && ((|prod5[50:0]) || keep[0]);
    end
    sum_p = {1'b0, keep} + 54'(rnd_p);
    m_p   = sum_p[53] ? {1'b1, 52'd0} : sum_p[52:0];
  end

  logic        v6, neg6, tr6, zero6;
  logic [52:0] m6;
  logic [11:0] eb6;

  // round the double to float32
  logic [24:0] sum_f;
  logic [11:0] exp_f;
  logic [31:0] bits_f;
  always_comb begin
    sum_f  = {1'b0, m6[52:29]} + 25'(m6[28] && ((|m6[27:0]) || m6[29]));
    exp_f  = eb6 + 12'(sum_f[24]) - EXP_OFFSET;
    bits_f = zero6 ? 32'd0 : {1'b0, exp_f[7:0], sum_f[24] ? 23'd0 : sum_f[22:0]};
    bits_f[31] = neg6;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc2  <= in_job.acc;
      neg2  <= in_job.neg;
      tr2   <= in_job.trunc;
      k2    <= in_job.frac_cnt;
      lz2   <= lz_in;
      zero2 <= (in_job.acc == '0);

      ma3   <= m_a;
      md3   <= {1'b1, dbits[51:0]};
      eb3   <= eb_a;
      neg3  <= neg2;
      tr3   <= tr2;
      zero3 <= zero2;

      pp_ll <= 54'(ma3[26:0] * md3[26:0]);
      pp_lh <= 53'(ma3[26:0] * md3[52:27]);
      pp_hl <= 53'(ma3[52:27] * md3[26:0]);
      pp_hh <= 52'(ma3[52:27] * md3[52:27]);
      eb4   <= eb3;
      neg4  <= neg3;
      tr4   <= tr3;
      zero4 <= zero3;

      prod5 <= 106'(pp_ll) + (106'(pp_lh) << 27) + (106'(pp_hl) << 27)
             + (106'(pp_hh) << 54);
      eb5   <= eb4;
      neg5  <= neg4;
      tr5   <= tr4;
      zero5 <= zero4;

      m6    <= m_p;
      eb6   <= eb5 + 12'(top) + 12'(sum_p[53]);
      neg6  <= neg5;
      tr6   <= tr5;
      zero6 <= zero5;

      number.value_bits         <= bits_f;
      number.fraction_truncated <= tr6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      number.valid <= 1'b0;
    end else if (en) begin
      v2 <= in_valid;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      number.valid <= v6;
    end
  end

  a_zero_mag : assert property (@(posedge clk) disable iff (rst)
    en && v6 && zero6 |=> number.value_bits[30:0] == 31'd0)
    else $error("zero integer gave nonzero magnitude");

endmodule

[rtl/ascii_decimal_float_scanner.sv]
// ascii_decimal_float_scanner: top level, scanner, job queue and converter
// depends on adfs_pkg, adfs_text_if, adfs_num_if, adfs_front, adfs_queue, adfs_back
//
//   channel  role  payload
//   text     sink  char_byte[7:0], flush
//   number   src   value_bits[31:0], fraction_truncated
//
// one text byte per cycle while the queue is not full; the scanner updates its
// number on each byte taken; a finished number is offered on number via the queue
// and 6 converter stages (lzc, normalise, partial products, product sum, double
// round, float round)
// rst is synchronous and clears the scan state, queue and pipeline valids
// a stall on number holds the pipeline; text stalls only when the queue fills
module ascii_decimal_float_scanner import adfs_pkg::*; #(
  parameter int MAX_FRACTION_DIGITS = 17
) (
  input logic        clk,
  input logic        rst,
  adfs_text_if.sink  text,
  adfs_num_if.source number
);

  logic q_full;
  logic take;
  logic emit;
  job_t front_job;
  logic q_valid;
  logic back_ready;
  job_t q_job;

  assign text.ready = !q_full;
  assign take       = text.valid && text.ready;

  adfs_front #(
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .char_byte(text.char_byte),
    .flush(text.flush),
    .emit(emit),
    .job(front_job)
  );

  adfs_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(emit),
    .push_job(front_job),
    .full(q_full),
    .pop_valid(q_valid),
    .pop_ready(back_ready),
    .pop_job(q_job)
  );

  adfs_back u_back (
    .clk(clk),
    .rst(rst),
    .in_valid(q_valid),
    .in_ready(back_ready),
    .in_job(q_job),
    .number(number)
  );

endmodule
